FILE: design/bplm_pkg.sv
package bplm_pkg;

    localparam int SLOT_COUNT_DEF       = 32;
    localparam int DISK_BLOCK_COUNT_DEF = 8192;
    localparam int AGE_BITS_DEF         = 16;

    localparam int KIND_W     = 2;
    localparam int BLK_W      = 16;
    localparam int BLK_CMP_W  = BLK_W + 1;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 5;
    localparam int WB_BLK_W   = 13;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP,
        KIND_ALLOC,
        KIND_SET_DIRTY,
        KIND_FLUSH
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_OOB,
        STATUS_MISS
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_status             status;
        logic [SLOT_W-1:0]   slot_index;
        logic                writeback_valid;
        logic [SLOT_W-1:0]   writeback_slot;
        logic [WB_BLK_W-1:0] writeback_block;
        logic                last;
    } t_result;

endpackage

FILE: design/bplm_if.sv
interface bplm_req_if import bplm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  block_number;

    modport source (output valid, output kind, output block_number, input ready);
    modport sink   (input valid, input kind, input block_number, output ready);
endinterface

interface bplm_rsp_if import bplm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_index;
    logic                writeback_valid;
    logic [SLOT_W-1:0]   writeback_slot;
    logic [WB_BLK_W-1:0] writeback_block;
    logic                last;

    modport source (output valid, output status, output slot_index, output writeback_valid,
                    output writeback_slot, output writeback_block, output last,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input writeback_valid,
                    input writeback_slot, input writeback_block, input last,
                    output ready);
endinterface

FILE: design/bplm_ram.sv
module bplm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bplm_engine.sv
module bplm_engine import bplm_pkg::*; #(
    parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
    parameter int DISK_BLOCK_COUNT = DISK_BLOCK_COUNT_DEF,
    parameter int AGE_BITS         = AGE_BITS_DEF,
    parameter int IDX_W            = $clog2(SLOT_COUNT),
    parameter int ENT_W            = 2 + $clog2(DISK_BLOCK_COUNT) + AGE_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bplm_req_if.sink         i_req,
    bplm_rsp_if.source       o_rsp,
    output logic             o_mem_we,
    output logic [IDX_W-1:0] o_mem_waddr,
    output logic [ENT_W-1:0] o_mem_wdata,
    output logic [IDX_W-1:0] o_mem_raddr,
    input  logic [ENT_W-1:0] i_mem_rdata
);

    localparam int TAG_W = $clog2(DISK_BLOCK_COUNT);
    localparam logic [IDX_W-1:0]    LAST_IDX = IDX_W'(SLOT_COUNT - 1);
    localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

    t_state               r_state, n_state;
    t_kind                r_kind, n_kind;
    logic [TAG_W-1:0]     r_tag, n_tag;
    logic                 r_oob, n_oob;
    logic [IDX_W-1:0]     r_addr, n_addr;
    // Hit of a lookup or set-dirty; during a flush, the dirty slot not yet sent.
    logic                 r_hit_v, n_hit_v;
    logic [IDX_W-1:0]     r_hit_idx, n_hit_idx;
    logic [TAG_W-1:0]     r_hit_tag, n_hit_tag;
    logic [AGE_BITS-1:0]  r_hit_age, n_hit_age;
    logic                 r_free_v, n_free_v;
    logic [IDX_W-1:0]     r_free_idx, n_free_idx;
    logic [IDX_W-1:0]     r_max_idx, n_max_idx;
    logic [AGE_BITS-1:0]  r_max_age, n_max_age;
    logic                 r_max_dirty, n_max_dirty;
    logic [TAG_W-1:0]     r_max_tag, n_max_tag;
    logic                 r_out_v, n_out_v;
    t_result              r_out, n_out;

    logic                 e_use;
    logic                 e_dirty;
    logic [TAG_W-1:0]     e_tag;
    logic [AGE_BITS-1:0]  e_age;
    logic [AGE_BITS-1:0]  w_age_inc;
    logic [AGE_BITS-1:0]  w_cand_age;
    logic                 w_accept;
    logic                 w_blk_oob;
    logic                 w_out_free;
    logic                 w_stall;
    logic                 w_scan_last;
    logic [IDX_W-1:0]     w_victim;
    logic                 w_victim_wb;

    assign e_use   = i_mem_rdata[ENT_W-1];
    assign e_dirty = i_mem_rdata[ENT_W-2];
    assign e_tag   = i_mem_rdata[AGE_BITS +: TAG_W];
    assign e_age   = i_mem_rdata[AGE_BITS-1:0];

    assign w_age_inc  = (e_age == AGE_MAX) ? e_age : AGE_BITS'(e_age + 1'b1);
    assign w_cand_age = e_use ? w_age_inc : e_age;

    assign i_req.ready = (r_state == ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_blk_oob   = BLK_CMP_W'(i_req.block_number) >= BLK_CMP_W'(DISK_BLOCK_COUNT);
    assign w_out_free  = !r_out_v || o_rsp.ready;
    // A second dirty slot cannot be taken while the previous one waits for the output.
    assign w_stall     = (r_kind == KIND_FLUSH) && e_dirty && r_hit_v && !w_out_free;
    assign w_scan_last = (r_addr == LAST_IDX);
    assign w_victim    = r_free_v ? r_free_idx : r_max_idx;
    assign w_victim_wb = !r_free_v && r_max_dirty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if ((t_kind'(i_req.kind) != KIND_FLUSH) && w_blk_oob) begin
                        n_state = ST_FINISH;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!w_stall && w_scan_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_kind      = r_kind;
        n_tag       = r_tag;
        n_oob       = r_oob;
        n_addr      = r_addr;
        n_hit_v     = r_hit_v;
        n_hit_idx   = r_hit_idx;
        n_hit_tag   = r_hit_tag;
        n_hit_age   = r_hit_age;
        n_free_v    = r_free_v;
        n_free_idx  = r_free_idx;
        n_max_idx   = r_max_idx;
        n_max_age   = r_max_age;
        n_max_dirty = r_max_dirty;
        n_max_tag   = r_max_tag;
        n_out_v     = r_out_v && !o_rsp.ready;
        n_out       = r_out;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_addr;
        o_mem_wdata = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_kind   = t_kind'(i_req.kind);
                    n_tag    = TAG_W'(i_req.block_number);
                    n_oob    = (t_kind'(i_req.kind) != KIND_FLUSH) && w_blk_oob;
                    n_addr   = '0;
                    n_hit_v  = 1'b0;
                    n_free_v = 1'b0;
                end
            end
            ST_SCAN: begin
                case (r_kind)
                    KIND_LOOKUP, KIND_SET_DIRTY: begin
                        if (!r_hit_v && e_use && (e_tag == r_tag)) begin
                            n_hit_v   = 1'b1;
                            n_hit_idx = r_addr;
                            n_hit_tag = e_tag;
                            n_hit_age = e_age;
                        end
                    end
                    KIND_ALLOC: begin
                        if (e_use) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {1'b1, e_dirty, e_tag, w_age_inc};
                        end else if (!r_free_v) begin
                            n_free_v   = 1'b1;
                            n_free_idx = r_addr;
                        end
                        if ((r_addr == '0) || (w_cand_age > r_max_age)) begin
                            n_max_idx   = r_addr;
                            n_max_age   = w_cand_age;
                            n_max_dirty = e_use && e_dirty;
                            n_max_tag   = e_tag;
                        end
                    end
                    KIND_FLUSH: begin
                        if (e_dirty && !w_stall) begin
                            o_mem_we    = 1'b1;
                            o_mem_wdata = {e_use, 1'b0, e_tag, e_age};
                            if (r_hit_v) begin
                                n_out_v = 1'b1;
                                n_out   = '{status: STATUS_OK, slot_index: '0,
                                            writeback_valid: 1'b1,
                                            writeback_slot: SLOT_W'(r_hit_idx),
                                            writeback_block: WB_BLK_W'(r_hit_tag),
                                            last: 1'b0};
                            end
                            n_hit_v   = 1'b1;
                            n_hit_idx = r_addr;
                            n_hit_tag = e_tag;
                        end
                    end
                    default: ;
                endcase
                if (!w_stall) begin
                    n_addr = w_scan_last ? '0 : IDX_W'(r_addr + 1'b1);
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_out_v = 1'b1;
                    n_out   = '{status: STATUS_OK, slot_index: '0, writeback_valid: 1'b0,
                                writeback_slot: '0, writeback_block: '0, last: 1'b1};
                    if (r_oob) begin
                        n_out.status = STATUS_OOB;
                    end else begin
                        case (r_kind)
                            KIND_LOOKUP, KIND_SET_DIRTY: begin
                                if (r_hit_v) begin
                                    n_out.slot_index = SLOT_W'(r_hit_idx);
                                    if (r_kind == KIND_SET_DIRTY) begin
                                        o_mem_we    = 1'b1;
                                        o_mem_waddr = r_hit_idx;
                                        o_mem_wdata = {1'b1, 1'b1, r_tag, r_hit_age};
                                    end
                                end else begin
                                    n_out.status = STATUS_MISS;
                                end
                            end
                            KIND_ALLOC: begin
                                n_out.slot_index = SLOT_W'(w_victim);
                                if (w_victim_wb) begin
                                    n_out.writeback_valid = 1'b1;
                                    n_out.writeback_slot  = SLOT_W'(w_victim);
                                    n_out.writeback_block = WB_BLK_W'(r_max_tag);
                                end
                                o_mem_we    = 1'b1;
                                o_mem_waddr = w_victim;
                                o_mem_wdata = {1'b1, 1'b0, r_tag, {AGE_BITS{1'b0}}};
                            end
                            KIND_FLUSH: begin
                                if (r_hit_v) begin
                                    n_out.writeback_valid = 1'b1;
                                    n_out.writeback_slot  = SLOT_W'(r_hit_idx);
                                    n_out.writeback_block = WB_BLK_W'(r_hit_tag);
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            default: ;
        endcase
    end

    // The read port follows the next scan address so data lines up with r_addr.
    assign o_mem_raddr = n_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_out_v <= 1'b0;
            r_hit_v <= 1'b0;
            r_addr  <= '0;
        end else begin
            r_state <= n_state;
            r_out_v <= n_out_v;
            r_hit_v <= n_hit_v;
            r_addr  <= n_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind      <= n_kind;
        r_tag       <= n_tag;
        r_oob       <= n_oob;
        r_hit_idx   <= n_hit_idx;
        r_hit_tag   <= n_hit_tag;
        r_hit_age   <= n_hit_age;
        r_free_v    <= n_free_v;
        r_free_idx  <= n_free_idx;
        r_max_idx   <= n_max_idx;
        r_max_age   <= n_max_age;
        r_max_dirty <= n_max_dirty;
        r_max_tag   <= n_max_tag;
        r_out       <= n_out;
    end

    assign o_rsp.valid           = r_out_v;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.slot_index      = r_out.slot_index;
    assign o_rsp.writeback_valid = r_out.writeback_valid;
    assign o_rsp.writeback_slot  = r_out.writeback_slot;
    assign o_rsp.writeback_block = r_out.writeback_block;
    assign o_rsp.last            = r_out.last;

endmodule

FILE: design/buffer_pool_lru_manager.sv
// Each request scans the slot table through the single read port of the slot memory,
// one slot per cycle: a new request is accepted only after the current one has put
// its last result into the output register; an out-of-bound request skips the scan.
// A flush also waits while a write-back result is held at the output.
// Reset is synchronous and active low; it marks every slot entry as unwritten so the
// table reads as all free at once, with no clearing pass.
module buffer_pool_lru_manager import bplm_pkg::*; #(
    parameter int SLOT_COUNT       = SLOT_COUNT_DEF,
    parameter int DISK_BLOCK_COUNT = DISK_BLOCK_COUNT_DEF,
    parameter int AGE_BITS         = AGE_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bplm_req_if.sink   i_req,
    bplm_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam int ENT_W = 2 + $clog2(DISK_BLOCK_COUNT) + AGE_BITS;

    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [ENT_W-1:0]      mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [ENT_W-1:0]      ram_rdata;
    logic [ENT_W-1:0]      mem_rdata;
    logic [SLOT_COUNT-1:0] r_written;
    logic                  r_rd_written;

    // An entry never written since reset reads as a free, clean slot.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            r_rd_written <= r_written[mem_raddr];
            if (mem_we) begin
                r_written[mem_waddr] <= 1'b1;
            end
        end
    end

    assign mem_rdata = r_rd_written ? ram_rdata : '0;

    bplm_ram #(
        .WIDTH (ENT_W),
        .DEPTH (SLOT_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (ram_rdata)
    );

    bplm_engine #(
        .SLOT_COUNT       (SLOT_COUNT),
        .DISK_BLOCK_COUNT (DISK_BLOCK_COUNT),
        .AGE_BITS         (AGE_BITS),
        .IDX_W            (IDX_W),
        .ENT_W            (ENT_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_rsp       (o_rsp),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

endmodule

FILE: design/bplm_chk.sv
module bplm_chk import bplm_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_req_valid,
    input logic                i_req_ready,
    input logic                i_rsp_valid,
    input logic                i_rsp_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [SLOT_W-1:0]   i_slot_index,
    input logic                i_wb_valid,
    input logic [SLOT_W-1:0]   i_wb_slot,
    input logic [WB_BLK_W-1:0] i_wb_block,
    input logic                i_last
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid &&
            $stable({i_status, i_slot_index, i_wb_valid, i_wb_slot, i_wb_block, i_last}))
        else $error("result changed while stalled");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another one is in progress");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && (i_status != STATUS_OK) |->
            (i_slot_index == '0) && !i_wb_valid && i_last)
        else $error("error result carries a slot or a write-back");

    a_wb_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_wb_valid |-> (i_wb_slot == '0) && (i_wb_block == '0))
        else $error("write-back fields set without a write-back");

    // Only a flush produces more than one result, each a write-back.
    a_flush_middle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_last |->
            i_wb_valid && (i_slot_index == '0) && (i_status == STATUS_OK))
        else $error("non-final result that is not a flush write-back");

endmodule

bind buffer_pool_lru_manager bplm_chk u_bplm_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_slot_index (o_rsp.slot_index),
    .i_wb_valid   (o_rsp.writeback_valid),
    .i_wb_slot    (o_rsp.writeback_slot),
    .i_wb_block   (o_rsp.writeback_block),
    .i_last       (o_rsp.last)
);
